FILE: rtl/page_table_walker_macros.svh
// Assertion macros shared by the page table walker RTL.
`ifndef PAGE_TABLE_WALKER_MACROS_SVH
`define PAGE_TABLE_WALKER_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define PTW_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define PTW_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/ptw_pkg.sv
// Shared constants and codes for the page table walker.
package ptw_pkg;

  localparam int MEM_WORDS_DEF = 4096;
  localparam int PHYS_BITS_DEF = 52;

  localparam int ADDR_BITS      = 52;
  localparam int VA_BITS        = 48;
  localparam int ENTRY_BITS     = 64;
  localparam int WORD_IDX_BITS  = 12;
  localparam int TBL_IDX_BITS   = 9;
  localparam int CFG_INDEX_BITS = 1;

  // Entry flag positions
  localparam int PTE_PRESENT = 0;
  localparam int PTE_PS      = 7;

  // Item kinds carried on tuser
  localparam logic OP_WRITE     = 1'b0;
  localparam logic OP_TRANSLATE = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_INDEX_BITS-1:0] CFG_ROOT   = 1'b0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_OFFSET = 1'b1;

  // Level codes; LVL_NONE also marks the root level during a walk
  localparam logic [1:0] LVL_4K   = 2'd0;
  localparam logic [1:0] LVL_2M   = 2'd1;
  localparam logic [1:0] LVL_1G   = 2'd2;
  localparam logic [1:0] LVL_NONE = 2'd3;

endpackage

FILE: rtl/page_table_walker.sv
// Four-level x86-64 page table walker over a local table memory.
//
// Input stream (s_*): one beat is one item. s_tuser selects the kind: a write
// beat stores write_data at word_index of the table memory and gives no result;
// a translate beat walks the tables for the virtual address and gives one result
// beat on the output stream (m_*).
// Configuration: cfg_we with cfg_index/cfg_data writes root_table_address
// (index 0) or memory_offset (index 1); write only while the walker is idle.
// Walk: a translate beat goes through, for each table level, the registered
// memory read with the range compare, then the entry decode and next table
// address, and last the load of the output register. Up to four dependent reads
// go through the single read port; m_tvalid rises and s_tready returns together,
// so a new beat is taken only once the result is in the output register. A write
// beat is taken while idle and needs no walk. One walk is in flight at a time.
// Reset: rst clears the state, out_valid and both configuration registers and
// starts a sweep that zeroes every word of the table memory; s_tready stays low until it has finished.
// Stall: a finished result waits in the output register; writes are still
// accepted meanwhile, and a following walk holds its result until the output
// register is free.
module page_table_walker #(
  parameter int MEM_WORDS = ptw_pkg::MEM_WORDS_DEF,
  parameter int PHYS_BITS = ptw_pkg::PHYS_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  // Input stream
  input  logic                                   s_tvalid,
  output logic                                   s_tready,
  // [11:0] word_index, [75:12] write_data, [123:76] virt_addr, [127:124] zero
  input  logic [127:0]                           s_tdata,
  // [0] op
  input  logic                                   s_tuser,
  // Output stream
  output logic                                   m_tvalid,
  input  logic                                   m_tready,
  // [0] mapped, [2:1] level_code, [54:3] physical_address, [118:55] leaf_entry,
  // [119] zero
  output logic [119:0]                           m_tdata,
  // Configuration write port
  input  logic                                   cfg_we,
  input  logic [ptw_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
  input  logic [ptw_pkg::ADDR_BITS-1:0]          cfg_data
);

  `include "page_table_walker_macros.svh"

  localparam int AW = $clog2(MEM_WORDS);
  localparam int IW = (AW > ptw_pkg::WORD_IDX_BITS) ? AW : ptw_pkg::WORD_IDX_BITS;
  localparam int RW = ptw_pkg::ADDR_BITS - 2;  // word address plus index carry

  localparam logic [ptw_pkg::ADDR_BITS-1:0] PHYS_MASK =
    ptw_pkg::ADDR_BITS'((64'd1 << PHYS_BITS) - 64'd1);
  localparam logic [ptw_pkg::ADDR_BITS-1:0] FRAME_MASK = PHYS_MASK & ~52'hFFF;
  localparam logic [ptw_pkg::ADDR_BITS-1:0] MASK_1G    = PHYS_MASK & ~52'h3FFF_FFFF;
  localparam logic [ptw_pkg::ADDR_BITS-1:0] MASK_2M    = PHYS_MASK & ~52'h1F_FFFF;

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_READ  = 5'b00100,
    ST_DATA  = 5'b01000,
    ST_DONE  = 5'b10000
  } state_t;

  state_t state;

  // Configuration registers
  logic [ptw_pkg::ADDR_BITS-1:0] root_table_address;
  logic [ptw_pkg::ADDR_BITS-1:0] memory_offset;

  // Input fields
  logic [ptw_pkg::WORD_IDX_BITS-1:0] in_word_index;
  logic [ptw_pkg::ENTRY_BITS-1:0]    in_write_data;
  logic [ptw_pkg::VA_BITS-1:0]       in_va;

  // Walk registers
  logic [ptw_pkg::VA_BITS-1:0]    va;
  logic [ptw_pkg::ADDR_BITS-1:0]  tbl_sum;   // offset plus table address, wrapped
  logic [1:0]                     lvl;
  logic                           oor;       // last read fell outside the memory

  // Result waiting for the output register
  logic                           res_mapped;
  logic [1:0]                     res_level;
  logic [ptw_pkg::ADDR_BITS-1:0]  res_phys;
  logic [ptw_pkg::ENTRY_BITS-1:0] res_leaf;

  // Output register
  logic                           out_valid;
  logic                           out_mapped;
  logic [1:0]                     out_level;
  logic [ptw_pkg::ADDR_BITS-1:0]  out_phys;
  logic [ptw_pkg::ENTRY_BITS-1:0] out_leaf;

  // Memory port
  logic                           mem_we;
  logic [AW-1:0]                  mem_waddr;
  logic                           mem_re;
  logic [AW-1:0]                  mem_raddr;
  logic [ptw_pkg::ENTRY_BITS-1:0] mem_rdata;
  logic                           mem_clearing;

  // Combinational walk terms
  logic [IW-1:0]                     wr_idx;
  logic                              wr_in_range;
  logic [ptw_pkg::TBL_IDX_BITS-1:0]  tbl_idx;
  logic [RW-1:0]                     rd_word;
  logic [ptw_pkg::ENTRY_BITS-1:0]    entry;
  logic                              present;
  logic                              ps;
  logic                              leaf_hit;
  logic                              descend;
  logic [ptw_pkg::ADDR_BITS-1:0]     leaf_phys;
  logic                              in_accept;
  logic                              out_free;

  assign in_word_index = s_tdata[11:0];
  assign in_write_data = s_tdata[75:12];
  assign in_va         = s_tdata[123:76];

  assign s_tready  = (state == ST_IDLE);
  assign in_accept = s_tvalid && s_tready;
  assign out_free  = !out_valid || m_tready;

  assign m_tvalid = out_valid;
  assign m_tdata  = {1'b0, out_leaf, out_phys, out_level, out_mapped};

  // Drop writes beyond the memory
  assign wr_idx      = IW'(in_word_index);
  assign wr_in_range = 32'(wr_idx) < 32'(MEM_WORDS);
  assign mem_we      = in_accept && (s_tuser == ptw_pkg::OP_WRITE) && wr_in_range;
  assign mem_waddr   = wr_idx[AW-1:0];

  // Entry index for the level being read
  always_comb begin
    unique case (lvl)
      ptw_pkg::LVL_NONE: tbl_idx = va[47:39];
      ptw_pkg::LVL_1G:   tbl_idx = va[38:30];
      ptw_pkg::LVL_2M:   tbl_idx = va[29:21];
      ptw_pkg::LVL_4K:   tbl_idx = va[20:12];
      default:           tbl_idx = va[20:12];
    endcase
  end

  assign rd_word   = RW'(tbl_sum[ptw_pkg::ADDR_BITS-1:3]) + RW'(tbl_idx);
  assign mem_re    = (state == ST_READ);
  assign mem_raddr = rd_word[AW-1:0];

  // Decode the entry just read; an out-of-range read counts as not present
  always_comb begin
    entry   = oor ? '0 : mem_rdata;
    present = entry[ptw_pkg::PTE_PRESENT];
    ps      = entry[ptw_pkg::PTE_PS];
    unique case (lvl)
      ptw_pkg::LVL_NONE: begin
        leaf_hit  = 1'b0;
        descend   = present;
        leaf_phys = '0;
      end
      ptw_pkg::LVL_1G: begin
        leaf_hit  = present && ps;
        descend   = present && !ps;
        leaf_phys = (entry[ptw_pkg::ADDR_BITS-1:0] & MASK_1G) |
                    ptw_pkg::ADDR_BITS'(va[29:0]);
      end
      ptw_pkg::LVL_2M: begin
        leaf_hit  = present && ps;
        descend   = present && !ps;
        leaf_phys = (entry[ptw_pkg::ADDR_BITS-1:0] & MASK_2M) |
                    ptw_pkg::ADDR_BITS'(va[20:0]);
      end
      default: begin
        leaf_hit  = present;
        descend   = 1'b0;
        leaf_phys = (entry[ptw_pkg::ADDR_BITS-1:0] & FRAME_MASK) |
                    ptw_pkg::ADDR_BITS'(va[11:0]);
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= ST_CLEAR;
      out_valid          <= 1'b0;
      root_table_address <= '0;
      memory_offset      <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          ptw_pkg::CFG_ROOT:   root_table_address <= cfg_data;
          ptw_pkg::CFG_OFFSET: memory_offset      <= cfg_data;
          default:             memory_offset      <= memory_offset;
        endcase
      end
      // Drop the taken beat unless a new result reloads the register below
      if (out_valid && m_tready && (state != ST_DONE)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_CLEAR: begin
          if (!mem_clearing) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_accept && (s_tuser == ptw_pkg::OP_TRANSLATE)) begin
            state <= ST_READ;
          end
        end
        ST_READ: begin
          state <= ST_DATA;
        end
        ST_DATA: begin
          state <= descend ? ST_READ : ST_DONE;
        end
        ST_DONE: begin
          if (out_free) begin
            out_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Walk and result payload
  always_ff @(posedge clk) begin
    if (in_accept && (s_tuser == ptw_pkg::OP_TRANSLATE)) begin
      va      <= in_va;
      tbl_sum <= memory_offset + (root_table_address & ~52'hFFF);
      lvl     <= ptw_pkg::LVL_NONE;
    end
    if (state == ST_READ) begin
      oor <= rd_word >= RW'(MEM_WORDS);
    end
    if (state == ST_DATA) begin
      if (descend) begin
        tbl_sum <= memory_offset + (entry[ptw_pkg::ADDR_BITS-1:0] & FRAME_MASK);
        lvl     <= lvl - 2'd1;
      end
      res_mapped <= leaf_hit;
      res_level  <= lvl;
      res_phys   <= leaf_hit ? leaf_phys : '0;
      res_leaf   <= leaf_hit ? entry : '0;
    end
    if ((state == ST_DONE) && out_free) begin
      out_mapped <= res_mapped;
      out_level  <= res_level;
      out_phys   <= res_phys;
      out_leaf   <= res_leaf;
    end
  end

  ptw_table_mem #(
    .MEM_WORDS (MEM_WORDS),
    .AW        (AW)
  ) u_mem (
    .clk      (clk),
    .rst      (rst),
    .we       (mem_we),
    .waddr    (mem_waddr),
    .wdata    (in_write_data),
    .re       (mem_re),
    .raddr    (mem_raddr),
    .rdata    (mem_rdata),
    .clearing (mem_clearing)
  );

  `PTW_ASSERT_IMP(a_no_beat_while_clearing, clk, rst, mem_clearing, !s_tready, "input taken during memory clear")
  `PTW_ASSERT_NXT(a_read_then_data, clk, rst, state == ST_READ, state == ST_DATA, "read not followed by data step")
  `PTW_ASSERT_IMP(a_unmapped_is_zero, clk, rst, out_valid && !out_mapped, (out_phys == '0) && (out_leaf == '0), "unmapped result carries data")
  `PTW_ASSERT_IMP(a_absent_root_unmapped, clk, rst, out_valid && (out_level == ptw_pkg::LVL_NONE), !out_mapped, "absent root reported as mapped")

endmodule

FILE: rtl/ptw_table_mem.sv
// Table memory: one write port, one registered read port, clearing sweep after reset.
module ptw_table_mem #(
  parameter int MEM_WORDS = ptw_pkg::MEM_WORDS_DEF,
  parameter int AW        = $clog2(MEM_WORDS)
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            we,
  input  logic [AW-1:0]                   waddr,
  input  logic [ptw_pkg::ENTRY_BITS-1:0]  wdata,
  input  logic                            re,
  input  logic [AW-1:0]                   raddr,
  output logic [ptw_pkg::ENTRY_BITS-1:0]  rdata,
  output logic                            clearing
);

  logic [ptw_pkg::ENTRY_BITS-1:0] mem [MEM_WORDS];
  logic [AW-1:0]                  clr_addr;
  logic                           port_we;
  logic [AW-1:0]                  port_addr;
  logic [ptw_pkg::ENTRY_BITS-1:0] port_data;

  // Sweep takes the write port while clearing
  always_comb begin
    if (clearing) begin
      port_we   = 1'b1;
      port_addr = clr_addr;
      port_data = '0;
    end else begin
      port_we   = we;
      port_addr = waddr;
      port_data = wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      if (clr_addr == AW'(MEM_WORDS - 1)) begin
        clearing <= 1'b0;
      end
      clr_addr <= clr_addr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (port_we) begin
      mem[port_addr] <= port_data;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: dv/tb_top.sv
// Self-checking testbench for the four-level page table walker.
`timescale 1ns / 1ps

module tb_top;
  import ptw_pkg::*;

  localparam int CYCLE_LIMIT   = 500000;
  localparam int SETTLE_CYCLES = 16;   // longer than the slowest walk plus a write
  localparam int HOLD_OFF_LEN  = 300;  // receiver hold-off used for back pressure

  // Result beat as it sits in m_tdata, lowest field last
  typedef struct packed {
    logic [ENTRY_BITS-1:0] leaf_entry;
    logic [ADDR_BITS-1:0]  physical_address;
    logic [1:0]            level_code;
    logic                  mapped;
  } walk_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                      s_tvalid = 1'b0;
  logic                      s_tready;
  // [11:0] word_index, [75:12] write_data, [123:76] virt_addr, [127:124] zero
  logic [127:0]              s_tdata  = '0;
  // [0] op
  logic                      s_tuser  = OP_WRITE;
  logic                      m_tvalid;
  logic                      m_tready = 1'b0;
  // [0] mapped, [2:1] level_code, [54:3] physical_address, [118:55] leaf_entry, [119] zero
  logic [119:0]              m_tdata;
  logic                      cfg_we    = 1'b0;
  logic [CFG_INDEX_BITS-1:0] cfg_index = CFG_ROOT;
  logic [ADDR_BITS-1:0]      cfg_data  = '0;

  page_table_walker u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #6 clk = ~clk;

  // Shadow copy of the walker state: table memory and both registers
  logic [ENTRY_BITS-1:0] table_mem [0:MEM_WORDS_DEF-1];
  logic [ADDR_BITS-1:0]  root_reg   = '0;
  logic [ADDR_BITS-1:0]  offset_reg = '0;

  walk_result_t pending_walks [$];   // translations accepted, result beat not yet seen
  int           mismatch_count = 0;
  int           cycle_count    = 0;

  // Idling controls and the receiver hold-off handshake between processes
  bit tx_idle_en    = 1'b1;
  bit rx_idle_en    = 1'b1;
  int stall_request = 0;   // bumped by the stimulus to ask for one long hold-off
  int stall_served  = 0;
  int hold_left     = 0;

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // Entry idx of the table at byte address table_base; zero beyond the memory.
  function automatic logic [ENTRY_BITS-1:0] fetch_entry(input logic [ADDR_BITS-1:0] table_base,
                                                        input logic [TBL_IDX_BITS-1:0] idx);
    logic [ADDR_BITS-1:0] byte_addr;
    logic [ADDR_BITS:0]   word;
    byte_addr = offset_reg + table_base;           // wraps at 2^52
    word      = {4'b0, byte_addr[ADDR_BITS-1:3]} + idx;  // low three bits dropped
    if (word >= MEM_WORDS_DEF) return '0;
    return table_mem[word[WORD_IDX_BITS-1:0]];
  endfunction

  function automatic logic [ADDR_BITS-1:0] table_frame(input logic [ENTRY_BITS-1:0] e);
    return {e[ADDR_BITS-1:12], 12'b0};
  endfunction

  function automatic walk_result_t predict_walk(input logic [VA_BITS-1:0] va);
    walk_result_t          r;
    logic [ENTRY_BITS-1:0] e;
    r = '0;
    r.level_code = LVL_NONE;
    e = fetch_entry({root_reg[ADDR_BITS-1:12], 12'b0}, va[47:39]);
    if (e[PTE_PRESENT]) begin
      e = fetch_entry(table_frame(e), va[38:30]);
      r.level_code = LVL_1G;
      if (e[PTE_PRESENT] && e[PTE_PS]) begin
        r.mapped           = 1'b1;
        r.leaf_entry       = e;
        r.physical_address = {e[ADDR_BITS-1:30], va[29:0]};
      end else if (e[PTE_PRESENT]) begin
        e = fetch_entry(table_frame(e), va[29:21]);
        r.level_code = LVL_2M;
        if (e[PTE_PRESENT] && e[PTE_PS]) begin
          r.mapped           = 1'b1;
          r.leaf_entry       = e;
          r.physical_address = {e[ADDR_BITS-1:21], va[20:0]};
        end else if (e[PTE_PRESENT]) begin
          // Page-size bit means nothing at the last level
          e = fetch_entry(table_frame(e), va[20:12]);
          r.level_code = LVL_4K;
          if (e[PTE_PRESENT]) begin
            r.mapped           = 1'b1;
            r.leaf_entry       = e;
            r.physical_address = {e[ADDR_BITS-1:12], va[11:0]};
          end
        end
      end
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Offer one beat from the falling edge, hold it until accepted, then update
  // the shadow state at the accepting edge.
  task automatic send_item(input logic op, input logic [WORD_IDX_BITS-1:0] widx,
                           input logic [ENTRY_BITS-1:0] wdata, input logic [VA_BITS-1:0] va);
    @(negedge clk);
    while (tx_idle_en && $urandom_range(0, 99) < 16) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tuser  = op;
    s_tdata  = {4'b0, va, wdata, widx};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (op == OP_WRITE) table_mem[widx] = wdata;
    else pending_walks.push_back(predict_walk(va));
  endtask

  // Drop valid and wait until every walk has reported, then let the block settle.
  task automatic drain_walks();
    @(negedge clk);
    s_tvalid = 1'b0;
    while (pending_walks.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Only call while the walker is idle.
  task automatic write_register(input logic [CFG_INDEX_BITS-1:0] idx,
                                input logic [ADDR_BITS-1:0] value);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == CFG_ROOT) root_reg = value;
    else offset_reg = value;
  endtask

  // Favour a handful of indexes so that random writes and walks meet often.
  function automatic logic [TBL_IDX_BITS-1:0] pick_table_index();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2, 3, 4: return TBL_IDX_BITS'($urandom_range(0, 3));
      default: return TBL_IDX_BITS'($urandom_range(0, 511));
    endcase
  endfunction

  // Random entry word; mostly aimed at one of the eight tables in memory under
  // the current offset, the rest pointing anywhere.
  function automatic logic [ENTRY_BITS-1:0] make_entry();
    logic [ENTRY_BITS-1:0] e;
    logic [ADDR_BITS-1:0]  target;
    e = {$urandom, $urandom};
    if ($urandom_range(0, 9) < 7) begin
      target = ADDR_BITS'($urandom_range(0, 7)) << 12;
      target = target - offset_reg;
      e[ADDR_BITS-1:12] = target[ADDR_BITS-1:12];
    end
    e[PTE_PRESENT] = ($urandom_range(0, 99) < 85);
    e[PTE_PS]      = ($urandom_range(0, 99) < 30);
    return e;
  endfunction

  // Mix of table writes and translations over the shared index set.
  task automatic run_walk_mix(input int count);
    logic [WORD_IDX_BITS-1:0] widx;
    logic [VA_BITS-1:0]       va;
    repeat (count) begin
      if ($urandom_range(0, 99) < 55) begin
        if ($urandom_range(0, 9) == 0) widx = WORD_IDX_BITS'($urandom);
        else widx = {3'($urandom_range(0, 7)), pick_table_index()};
        send_item(OP_WRITE, widx, make_entry(), VA_BITS'({$urandom, $urandom}));
      end else begin
        if ($urandom_range(0, 4) == 0) va = VA_BITS'({$urandom, $urandom});
        else va = {pick_table_index(), pick_table_index(), pick_table_index(),
                   pick_table_index(), 12'($urandom)};
        send_item(OP_TRANSLATE, WORD_IDX_BITS'($urandom), {$urandom, $urandom}, va);
      end
    end
  endtask

  task automatic run_phase(input logic [ADDR_BITS-1:0] root, input logic [ADDR_BITS-1:0] offset,
                           input int count);
    drain_walks();
    write_register(CFG_ROOT, root);
    write_register(CFG_OFFSET, offset);
    run_walk_mix(count);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Hand-built tables with root and offset at zero; tables live at 4KB pages.
  task automatic test_directed();
    send_item(OP_TRANSLATE, '0, '0, '0);                       // empty memory
    send_item(OP_TRANSLATE, '1, '1, '1);
    send_item(OP_WRITE, 12'd0, 64'h8000_0000_0000_1003, '0);    // root[0] -> page 1
    send_item(OP_TRANSLATE, '0, '0, '0);                       // directory-pointer absent
    send_item(OP_WRITE, 12'd512, '1, '0);                      // 1GB leaf, all bits set
    send_item(OP_TRANSLATE, '0, '0, 48'h0000_3FFF_FFFF);
    send_item(OP_WRITE, 12'd511, 64'h0000_0000_0000_2001, '0);  // root[511] -> page 2
    send_item(OP_WRITE, 12'd1535, 64'h0000_0000_0000_3003, '0); // page 2 [511] -> page 3
    send_item(OP_WRITE, 12'd2047, 64'h000F_FFFF_FFE0_0081, '0); // 2MB leaf
    send_item(OP_TRANSLATE, '0, '0, '1);
    send_item(OP_WRITE, 12'd2046, 64'h0000_0000_0000_4001, '0); // page 3 [510] -> page 4
    send_item(OP_WRITE, 12'd2559, '1, '0);                     // 4KB leaf with page-size set
    send_item(OP_TRANSLATE, '0, '0, {9'h1FF, 9'h1FF, 9'h1FE, 9'h1FF, 12'hFFF});
    send_item(OP_WRITE, 12'd2048, 64'hFFFF_FFFF_FFFF_FFFE, '0); // 4KB entry absent
    send_item(OP_TRANSLATE, '0, '0, {9'h1FF, 9'h1FF, 9'h1FE, 9'h000, 12'h000});
    send_item(OP_WRITE, 12'd1536, 64'h0000_0000_0000_0080, '0); // 2MB size bit, not present
    send_item(OP_TRANSLATE, '0, '0, {9'h1FF, 9'h1FF, 9'h000, 9'h0AA, 12'h555});
    send_item(OP_WRITE, 12'd1537, 64'h0000_0000_0010_0001, '0); // table beyond the memory
    send_item(OP_TRANSLATE, '0, '0, {9'h1FF, 9'h1FF, 9'h001, 9'h005, 12'h123});
    send_item(OP_WRITE, 12'd4095, '1, '0);                     // top word
    send_item(OP_TRANSLATE, '0, '0, '0);                       // address zero, 1GB page
  endtask

  // Several register settings, extremes and wrap-around among them.
  task automatic test_random_walks();
    run_phase('0, '0, 330);
    run_phase(52'h0000_0000_0_3ABC, '0, 330);                 // low root bits ignored
    run_phase('1, 52'h0000_0000_0_5000, 330);                 // root plus offset wraps
    run_phase(52'h0000_0000_0_2000, '1, 330);                 // unaligned, wraps to word 1023
    run_phase(52'h0000_0000_0_8000, '0, 30);                  // root just beyond the memory
    run_phase((ADDR_BITS'($urandom_range(0, 7)) << 12) | ADDR_BITS'($urandom_range(0, 4095)),
              ADDR_BITS'($urandom_range(0, 16'h3000)), 300);
  endtask

  // A long stretch with neither side idling.
  task automatic test_full_rate();
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    run_walk_mix(150);
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
  endtask

  // Hold the receiver off while translations keep coming, so the walker fills
  // and stalls its input; then pause the sender until everything has drained.
  task automatic test_back_pressure();
    drain_walks();
    stall_request = stall_request + 1;
    repeat (40)
      send_item(OP_TRANSLATE, '0, '0, {pick_table_index(), pick_table_index(),
                                       pick_table_index(), pick_table_index(), 12'($urandom)});
    drain_walks();
  endtask

  // ---------------------------------------------------------------------------
  // Receiver, checker and watchdog
  // ---------------------------------------------------------------------------

  always @(negedge clk) begin
    if (stall_request != stall_served) begin
      stall_served = stall_request;
      hold_left    = HOLD_OFF_LEN;
    end
    if (hold_left > 0) begin
      m_tready  = 1'b0;
      hold_left = hold_left - 1;
    end else begin
      m_tready = !(rx_idle_en && $urandom_range(0, 99) < 16);
    end
  end

  walk_result_t seen_result, want_result;

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      seen_result = m_tdata[118:0];
      if (pending_walks.size() == 0) begin
        $error("result beat with no translation outstanding: %h", m_tdata);
        mismatch_count++;
      end else begin
        want_result = pending_walks.pop_front();
        if (seen_result.mapped !== want_result.mapped) begin
          $error("mapped: expected %0d, got %0d", want_result.mapped, seen_result.mapped);
          mismatch_count++;
        end
        if (seen_result.level_code !== want_result.level_code) begin
          $error("level_code: expected %0d, got %0d",
                 want_result.level_code, seen_result.level_code);
          mismatch_count++;
        end
        if (seen_result.physical_address !== want_result.physical_address) begin
          $error("physical_address: expected %h, got %h",
                 want_result.physical_address, seen_result.physical_address);
          mismatch_count++;
        end
        if (seen_result.leaf_entry !== want_result.leaf_entry) begin
          $error("leaf_entry: expected %h, got %h",
                 want_result.leaf_entry, seen_result.leaf_entry);
          mismatch_count++;
        end
      end
    end
  end

  // Covers the clearing sweep after reset with plenty to spare.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < MEM_WORDS_DEF; i++) table_mem[i] = '0;
    repeat (6) @(negedge clk);
    rst = 1'b0;

    test_directed();
    test_random_walks();
    test_full_rate();
    test_back_pressure();

    drain_walks();
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

FILE: page_table_walker.f
+incdir+rtl
rtl/ptw_pkg.sv
rtl/ptw_table_mem.sv
rtl/page_table_walker.sv
dv/tb_top.sv
